### hw/rtl/bss_pkg.sv
// Shared constants and types for the box subtract/split block.
package bss_pkg;

    // Default coordinate width and job queue depth
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Number of coordinates carried by one item and by one piece
    localparam int NUM_IN_COORD    = 12;
    localparam int NUM_OUT_COORD   = 6;
    localparam int NUM_PIECE       = 6;

    // Coordinate slots of an item
    localparam int IDX_SX0 = 0;
    localparam int IDX_SY0 = 1;
    localparam int IDX_SZ0 = 2;
    localparam int IDX_SX1 = 3;
    localparam int IDX_SY1 = 4;
    localparam int IDX_SZ1 = 5;
    localparam int IDX_CX0 = 6;
    localparam int IDX_CY0 = 7;
    localparam int IDX_CZ0 = 8;
    localparam int IDX_CX1 = 9;
    localparam int IDX_CY1 = 10;
    localparam int IDX_CZ1 = 11;

    // Coordinate slots of a piece
    localparam int OUT_X0 = 0;
    localparam int OUT_Y0 = 1;
    localparam int OUT_Z0 = 2;
    localparam int OUT_X1 = 3;
    localparam int OUT_Y1 = 4;
    localparam int OUT_Z1 = 5;

    // Piece slots, in emission order
    localparam int PC_Z_LO = 0;
    localparam int PC_Z_HI = 1;
    localparam int PC_X_LO = 2;
    localparam int PC_X_HI = 3;
    localparam int PC_Y_LO = 4;
    localparam int PC_Y_HI = 5;

    // Classification of one item
    typedef struct packed {
        logic                 hit;
        logic [NUM_PIECE-1:0] mask;
    } job_ctl_t;

endpackage

### hw/rtl/bss_fifo.sv
// Small register queue of classified jobs between front and back.
module bss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             rd_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/bss_front.sv
// Front end: overlap test and per-piece conditions for one item.
module bss_front #(
    parameter int COORD_WIDTH = bss_pkg::COORD_WIDTH_DEF
) (
    input  logic [bss_pkg::NUM_IN_COORD-1:0][COORD_WIDTH-1:0] coord,
    output bss_pkg::job_ctl_t                                 ctl
);
    import bss_pkg::*;

    function automatic logic lt(input logic [COORD_WIDTH-1:0] a,
                                input logic [COORD_WIDTH-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // strict overlap on all three axes
    assign ctl.hit = lt(coord[IDX_SX0], coord[IDX_CX1]) && lt(coord[IDX_CX0], coord[IDX_SX1])
                  && lt(coord[IDX_SY0], coord[IDX_CY1]) && lt(coord[IDX_CY0], coord[IDX_SY1])
                  && lt(coord[IDX_SZ0], coord[IDX_CZ1]) && lt(coord[IDX_CZ0], coord[IDX_SZ1]);

    // the same flags later pick the clipped bounds (max of mins, min of maxes)
    assign ctl.mask[PC_Z_LO] = lt(coord[IDX_SZ0], coord[IDX_CZ0]);
    assign ctl.mask[PC_Z_HI] = lt(coord[IDX_CZ1], coord[IDX_SZ1]);
    assign ctl.mask[PC_X_LO] = lt(coord[IDX_SX0], coord[IDX_CX0]);
    assign ctl.mask[PC_X_HI] = lt(coord[IDX_CX1], coord[IDX_SX1]);
    assign ctl.mask[PC_Y_LO] = lt(coord[IDX_SY0], coord[IDX_CY0]);
    assign ctl.mask[PC_Y_HI] = lt(coord[IDX_CY1], coord[IDX_SY1]);

endmodule

### hw/rtl/bss_back.sv
// Back end: walks the piece mask of the head job, one piece per cycle while results are popped.
module bss_back #(
    parameter int COORD_WIDTH = bss_pkg::COORD_WIDTH_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               job_valid,
    input  bss_pkg::job_ctl_t                                  job_ctl,
    input  logic [bss_pkg::NUM_IN_COORD-1:0][COORD_WIDTH-1:0]  job_coord,
    output logic                                               job_pop,
    input  logic                                               pop,
    output logic                                               empty,
    output logic [bss_pkg::NUM_OUT_COORD-1:0][COORD_WIDTH-1:0] out_coord,
    output logic                                               out_last,
    output logic                                               out_empty
);
    import bss_pkg::*;

    logic                                      out_valid_reg;
    logic [NUM_OUT_COORD-1:0][COORD_WIDTH-1:0] coord_reg, coord_next;
    logic                                      last_reg, empty_reg, empty_next;
    logic                                      started_reg, started_next;
    logic [NUM_PIECE-1:0]                      rem_reg, rem_next;
    logic [NUM_PIECE-1:0]                      cur, sel, rem_after;
    logic                                      out_load, single, done;
    logic [COORD_WIDTH-1:0]                    z0, z1, x0, x1;

    assign empty     = !out_valid_reg;
    assign out_coord = coord_reg;
    assign out_last  = last_reg;
    assign out_empty = empty_reg;

    assign out_load  = job_valid && (!out_valid_reg || pop);
    assign cur       = started_reg ? rem_reg : job_ctl.mask;
    assign sel       = cur & (~cur + 1'b1);
    assign rem_after = cur & ~sel;
    assign single    = !job_ctl.hit || (cur == '0);
    assign done      = single || (rem_after == '0);
    assign job_pop   = out_load && done;

    // clipped bounds of the overlap
    assign z0 = job_ctl.mask[PC_Z_LO] ? job_coord[IDX_CZ0] : job_coord[IDX_SZ0];
    assign z1 = job_ctl.mask[PC_Z_HI] ? job_coord[IDX_CZ1] : job_coord[IDX_SZ1];
    assign x0 = job_ctl.mask[PC_X_LO] ? job_coord[IDX_CX0] : job_coord[IDX_SX0];
    assign x1 = job_ctl.mask[PC_X_HI] ? job_coord[IDX_CX1] : job_coord[IDX_SX1];

    always_comb
    begin
        empty_next         = 1'b0;
        coord_next[OUT_X0] = job_coord[IDX_SX0];
        coord_next[OUT_Y0] = job_coord[IDX_SY0];
        coord_next[OUT_Z0] = job_coord[IDX_SZ0];
        coord_next[OUT_X1] = job_coord[IDX_SX1];
        coord_next[OUT_Y1] = job_coord[IDX_SY1];
        coord_next[OUT_Z1] = job_coord[IDX_SZ1];
        if (!job_ctl.hit)
        begin
            // no overlap: source passes unchanged
        end
        else if (cur == '0)
        begin
            coord_next = '0;
            empty_next = 1'b1;
        end
        else if (sel[PC_Z_LO])
        begin
            coord_next[OUT_Z1] = job_coord[IDX_CZ0];
        end
        else if (sel[PC_Z_HI])
        begin
            coord_next[OUT_Z0] = job_coord[IDX_CZ1];
        end
        else if (sel[PC_X_LO])
        begin
            coord_next[OUT_Z0] = z0;
            coord_next[OUT_X1] = job_coord[IDX_CX0];
            coord_next[OUT_Z1] = z1;
        end
        else if (sel[PC_X_HI])
        begin
            coord_next[OUT_X0] = job_coord[IDX_CX1];
            coord_next[OUT_Z0] = z0;
            coord_next[OUT_Z1] = z1;
        end
        else if (sel[PC_Y_LO])
        begin
            coord_next[OUT_X0] = x0;
            coord_next[OUT_Z0] = z0;
            coord_next[OUT_X1] = x1;
            coord_next[OUT_Y1] = job_coord[IDX_CY0];
            coord_next[OUT_Z1] = z1;
        end
        else
        begin
            coord_next[OUT_X0] = x0;
            coord_next[OUT_Y0] = job_coord[IDX_CY1];
            coord_next[OUT_Z0] = z0;
            coord_next[OUT_X1] = x1;
            coord_next[OUT_Z1] = z1;
        end
    end

    always_comb
    begin
        started_next = started_reg;
        rem_next     = rem_reg;
        if (out_load)
        begin
            started_next = !done;
            rem_next     = rem_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (out_load)
        begin
            coord_reg <= coord_next;
            last_reg  <= done;
            empty_reg <= empty_next;
        end
    end

endmodule

### hw/rtl/box_subtract_split_core.sv
// Top level of the box subtract/split block: front, job queue and back.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  input   | push / full        | src_min_*, src_max_*, cut_min_*, cut_max_* (x,y,z)
//  result  | pop / empty        | piece_min_*, piece_max_*, piece_last, remainder_empty
//
// Cycles: an item is taken in any cycle while the job queue (QUEUE_DEPTH jobs) has room;
// it is written into the queue, then into the back end's output register. The back end
// emits one piece per cycle while results are popped, so an item yields 1 to 6 pieces;
// the single result port limits the sustained item rate.
// Reset: rst_n clears the queue and the output valid flag; no clearing pass.
// Stalls: a held pop only stops the back end; the front keeps filling the queue until it is full.
module box_subtract_split_core #(
    parameter int COORD_WIDTH = bss_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] src_min_x,
    input  logic signed [COORD_WIDTH-1:0] src_min_y,
    input  logic signed [COORD_WIDTH-1:0] src_min_z,
    input  logic signed [COORD_WIDTH-1:0] src_max_x,
    input  logic signed [COORD_WIDTH-1:0] src_max_y,
    input  logic signed [COORD_WIDTH-1:0] src_max_z,
    input  logic signed [COORD_WIDTH-1:0] cut_min_x,
    input  logic signed [COORD_WIDTH-1:0] cut_min_y,
    input  logic signed [COORD_WIDTH-1:0] cut_min_z,
    input  logic signed [COORD_WIDTH-1:0] cut_max_x,
    input  logic signed [COORD_WIDTH-1:0] cut_max_y,
    input  logic signed [COORD_WIDTH-1:0] cut_max_z,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] piece_min_x,
    output logic signed [COORD_WIDTH-1:0] piece_min_y,
    output logic signed [COORD_WIDTH-1:0] piece_min_z,
    output logic signed [COORD_WIDTH-1:0] piece_max_x,
    output logic signed [COORD_WIDTH-1:0] piece_max_y,
    output logic signed [COORD_WIDTH-1:0] piece_max_z,
    output logic                          piece_last,
    output logic                          remainder_empty
);
    import bss_pkg::*;

    localparam int COORDS_W = NUM_IN_COORD * COORD_WIDTH;
    localparam int JOB_W    = $bits(job_ctl_t) + COORDS_W;

    logic [NUM_IN_COORD-1:0][COORD_WIDTH-1:0]  in_coord;
    logic [NUM_IN_COORD-1:0][COORD_WIDTH-1:0]  job_coord;
    logic [NUM_OUT_COORD-1:0][COORD_WIDTH-1:0] out_coord;
    job_ctl_t                                  in_ctl, job_ctl;
    logic [JOB_W-1:0]                          q_wr_data, q_rd_data;
    logic                                      job_valid, job_pop;

    assign in_coord[IDX_SX0] = src_min_x;
    assign in_coord[IDX_SY0] = src_min_y;
    assign in_coord[IDX_SZ0] = src_min_z;
    assign in_coord[IDX_SX1] = src_max_x;
    assign in_coord[IDX_SY1] = src_max_y;
    assign in_coord[IDX_SZ1] = src_max_z;
    assign in_coord[IDX_CX0] = cut_min_x;
    assign in_coord[IDX_CY0] = cut_min_y;
    assign in_coord[IDX_CZ0] = cut_min_z;
    assign in_coord[IDX_CX1] = cut_max_x;
    assign in_coord[IDX_CY1] = cut_max_y;
    assign in_coord[IDX_CZ1] = cut_max_z;

    // classify on the way in
    bss_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .coord(in_coord),
        .ctl  (in_ctl)
    );

    assign q_wr_data = {in_ctl, in_coord};

    // job queue decouples intake from piece emission
    bss_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (q_rd_data),
        .rd_valid(job_valid)
    );

    assign job_ctl   = q_rd_data[JOB_W-1:COORDS_W];
    assign job_coord = q_rd_data[COORDS_W-1:0];

    // piece generator with registered result
    bss_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(job_valid),
        .job_ctl  (job_ctl),
        .job_coord(job_coord),
        .job_pop  (job_pop),
        .pop      (pop),
        .empty    (empty),
        .out_coord(out_coord),
        .out_last (piece_last),
        .out_empty(remainder_empty)
    );

    assign piece_min_x = out_coord[OUT_X0];
    assign piece_min_y = out_coord[OUT_Y0];
    assign piece_min_z = out_coord[OUT_Z0];
    assign piece_max_x = out_coord[OUT_X1];
    assign piece_max_y = out_coord[OUT_Y1];
    assign piece_max_z = out_coord[OUT_Z1];

    // an empty remainder is always the only, hence last, result
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && remainder_empty) |-> piece_last)
        else $error("empty remainder not marked last");

    // an empty remainder carries zero coordinates
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && remainder_empty) |->
            (piece_min_x == '0 && piece_min_y == '0 && piece_min_z == '0 &&
             piece_max_x == '0 && piece_max_y == '0 && piece_max_z == '0))
        else $error("empty remainder with nonzero coordinates");

    // the pieces of one item follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !piece_last) |=> !empty)
        else $error("gap between pieces of one item");

    // the back end never takes a job from an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job pop from empty queue");

endmodule
